FILE: design/sed_pkg.sv
package sed_pkg;

  // most result words one input word can cause
  localparam int NOUT = 3;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_X_LO   = 8'h78;
  localparam logic [7:0] CH_X_UP   = 8'h58;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;

  localparam logic [7:0] QUOTE_RESET = CH_DQUOTE;

  typedef enum logic [2:0] {
    PH_NORMAL = 3'd0,
    PH_ESC    = 3'd1,
    PH_HEX0   = 3'd2,
    PH_HEX1   = 3'd3,
    PH_OCT1   = 3'd4,
    PH_OCT2   = 3'd5
  } sed_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       string_end;
  } sed_res_t;

  typedef struct packed {
    logic [1:0]          cnt;
    sed_res_t [NOUT-1:0] res;
  } sed_dec_t;

  // {valid, value}
  function automatic logic [4:0] hex_val(logic [7:0] b);
    logic [7:0] t;
    logic [4:0] r;
    r = 5'd0;
    t = 8'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      t = b - 8'h30;
      r = {1'b1, t[3:0]};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      t = b - 8'h57;
      r = {1'b1, t[3:0]};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      t = b - 8'h37;
      r = {1'b1, t[3:0]};
    end
    return r;
  endfunction

  function automatic logic is_oct(logic [7:0] b);
    return (b >= CH_0) && (b <= CH_7);
  endfunction

endpackage

FILE: design/string_escape_decoder.sv
// channel | dir | handshake              | payload
// in      | in  | in_tvalid/in_tready    | in_tdata[7:0] raw byte, in_tlast end of string
// out     | out | out_tvalid/out_tready  | out_tdata[7:0] byte, out_tuser run end,
//         |     |                        | out_tlast end of string
// cfg     | in  | cfg_valid/cfg_ready    | cfg_data[7:0] quote character
//
// one input word per cycle while the queue has room; the decode sits between the input register and
// a result queue of FIFO_DEPTH words, so a result passes the input register, then the queue, before it is valid
// the queue drains one result per cycle while out_tready is high; a word causing up to three results
// needs three free slots before it leaves the input register
// rst_n is synchronous, active low; quote character resets to double quote
// a stall on the output fills the queue, then in_tready drops
module string_escape_decoder import sed_pkg::*; #(
  parameter int FIFO_DEPTH = 8  // power of two, at least 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // [0] run_end
  output logic       out_tlast,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data    // [7:0] quote_char
);

  logic       s1_valid_r;
  logic [7:0] s1_data_r;
  logic       s1_last_r;
  logic [7:0] quote_r;
  logic       room;
  logic       dec_fire;
  logic [1:0] wr_cnt;
  sed_dec_t   dec;
  sed_res_t   rd_res;

  assign cfg_ready = 1'b1;
  assign dec_fire  = s1_valid_r && room;
  assign in_tready = !s1_valid_r || dec_fire;
  assign wr_cnt    = dec_fire ? dec.cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      quote_r    <= QUOTE_RESET;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (cfg_valid) quote_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  sed_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (dec_fire),
    .in_data (s1_data_r),
    .in_last (s1_last_r),
    .quote   (quote_r),
    .dec     (dec)
  );

  sed_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_cnt   (wr_cnt),
    .wr_res   (dec.res),
    .room     (room),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_res   (rd_res)
  );

  assign out_tdata = rd_res.data;
  assign out_tuser = rd_res.run_end;
  assign out_tlast = rd_res.string_end;

endmodule

FILE: design/sed_decode.sv
module sed_decode import sed_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] in_data,
  input  logic       in_last,
  input  logic [7:0] quote,
  output sed_dec_t   dec
);

  sed_phase_t phase_r, phase_nxt, ph_mid;
  logic [5:0] dv_r, dv_nxt, dv_mid;
  logic       xu_r, xu_nxt, xu_mid;
  logic       plain;
  logic       single;
  logic [4:0] hv;
  logic       oct;
  logic [2:0] od;
  logic [7:0] ob [4];
  logic [1:0] n;

  assign single = (quote == CH_SQUOTE);
  assign hv     = hex_val(in_data);
  assign oct    = is_oct(in_data);
  assign od     = in_data[2:0];

  // next state
  always_comb begin
    ph_mid = phase_r;
    dv_mid = dv_r;
    xu_mid = xu_r;
    plain  = 1'b0;
    case (phase_r)
      PH_ESC: begin
        ph_mid = PH_NORMAL;
        if (!single && (in_data == CH_X_LO || in_data == CH_X_UP)) begin
          xu_mid = (in_data == CH_X_UP);
          ph_mid = PH_HEX0;
        end else if (!single && oct) begin
          dv_mid = {3'd0, od};
          ph_mid = PH_OCT1;
        end
      end
      PH_HEX0: begin
        if (hv[4]) begin
          dv_mid = {2'd0, hv[3:0]};
          ph_mid = PH_HEX1;
        end else begin
          ph_mid = PH_NORMAL;
          plain  = 1'b1;
        end
      end
      PH_HEX1: begin
        ph_mid = PH_NORMAL;
        plain  = !hv[4];
      end
      PH_OCT1: begin
        if (oct) begin
          dv_mid = {dv_r[2:0], od};
          ph_mid = PH_OCT2;
        end else begin
          ph_mid = PH_NORMAL;
          plain  = 1'b1;
        end
      end
      PH_OCT2: begin
        ph_mid = PH_NORMAL;
        plain  = !oct;
      end
      default: begin
        ph_mid = PH_NORMAL;
        plain  = 1'b1;
      end
    endcase
    if (plain && in_data == CH_BSLASH) ph_mid = PH_ESC;

    if (in_last) begin
      phase_nxt = PH_NORMAL;
      dv_nxt    = 6'd0;
      xu_nxt    = 1'b0;
    end else begin
      phase_nxt = ph_mid;
      dv_nxt    = dv_mid;
      xu_nxt    = xu_mid;
    end
  end

  // emitted words
  always_comb begin
    for (int k = 0; k < 4; k++) ob[k] = 8'd0;
    n = 2'd0;
    case (phase_r)
      PH_ESC: begin
        if (single) begin
          if (in_data == CH_BSLASH || in_data == CH_SQUOTE) begin
            ob[n] = in_data; n = n + 2'd1;
          end else begin
            ob[n] = CH_BSLASH; n = n + 2'd1;
            ob[n] = in_data;   n = n + 2'd1;
          end
        end else begin
          case (in_data)
            CH_N:      begin ob[n] = CH_LF;     n = n + 2'd1; end
            CH_T:      begin ob[n] = CH_TAB;    n = n + 2'd1; end
            CH_R:      begin ob[n] = CH_CR;     n = n + 2'd1; end
            CH_V:      begin ob[n] = CH_VT;     n = n + 2'd1; end
            CH_F:      begin ob[n] = CH_FF;     n = n + 2'd1; end
            CH_BSLASH: begin ob[n] = CH_BSLASH; n = n + 2'd1; end
            CH_DOLLAR: begin ob[n] = CH_DOLLAR; n = n + 2'd1; end
            CH_DQUOTE: begin
              if (quote != CH_DQUOTE) begin
                ob[n] = CH_BSLASH; n = n + 2'd1;
              end
              ob[n] = CH_DQUOTE; n = n + 2'd1;
            end
            CH_X_LO, CH_X_UP: begin
            end
            default: begin
              if (!oct) begin
                ob[n] = CH_BSLASH; n = n + 2'd1;
                ob[n] = in_data;   n = n + 2'd1;
              end
            end
          endcase
        end
      end
      PH_HEX0: begin
        if (!hv[4]) begin
          ob[n] = CH_BSLASH;                  n = n + 2'd1;
          ob[n] = xu_r ? CH_X_UP : CH_X_LO;   n = n + 2'd1;
        end
      end
      PH_HEX1: begin
        if (hv[4]) ob[n] = {dv_r[3:0], hv[3:0]};
        else       ob[n] = {2'd0, dv_r};
        n = n + 2'd1;
      end
      PH_OCT1: begin
        if (!oct) begin
          ob[n] = {2'd0, dv_r}; n = n + 2'd1;
        end
      end
      PH_OCT2: begin
        // three octal digits wrap to eight bits
        if (oct) ob[n] = {dv_r[4:0], od};
        else     ob[n] = {2'd0, dv_r};
        n = n + 2'd1;
      end
      default: begin
      end
    endcase
    if (plain && in_data != CH_BSLASH) begin
      ob[n] = in_data; n = n + 2'd1;
    end
    // flush whatever escape is still open at the end of the string
    if (in_last) begin
      case (ph_mid)
        PH_ESC: begin
          ob[n] = CH_BSLASH; n = n + 2'd1;
        end
        PH_HEX0: begin
          ob[n] = CH_BSLASH;                  n = n + 2'd1;
          ob[n] = xu_mid ? CH_X_UP : CH_X_LO; n = n + 2'd1;
        end
        PH_HEX1, PH_OCT1, PH_OCT2: begin
          ob[n] = {2'd0, dv_mid}; n = n + 2'd1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    dec.cnt = n;
    for (int k = 0; k < NOUT; k++) begin
      dec.res[k].data       = ob[k];
      dec.res[k].run_end    = (2'(k + 1) == n);
      dec.res[k].string_end = (2'(k + 1) == n) && in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NORMAL;
      dv_r    <= 6'd0;
      xu_r    <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      dv_r    <= dv_nxt;
      xu_r    <= xu_nxt;
    end
  end

`ifndef SYNTHESIS
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_last |=> phase_r == PH_NORMAL && dv_r == 6'd0 && !xu_r)
    else $error("escape state left open after end of string");

  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_last |-> dec.cnt != 2'd0)
    else $error("end of string produced no word");

  a_oct1_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_OCT1 |-> dv_r < 6'd8)
    else $error("first octal digit out of range");

  a_hex1_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEX1 |-> dv_r < 6'd16)
    else $error("first hex digit out of range");
`endif

endmodule

FILE: design/sed_out_fifo.sv
module sed_out_fifo import sed_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          wr_cnt,
  input  sed_res_t [NOUT-1:0] wr_res,
  output logic                room,
  output logic                rd_valid,
  input  logic                rd_ready,
  output sed_res_t            rd_res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  sed_res_t        mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r, count_nxt;
  logic            pop;

  assign rd_valid  = (count_r != '0);
  assign rd_res    = mem_r[rd_ptr_r];
  assign pop       = rd_valid && rd_ready;
  // space for a full burst of results
  assign room      = (count_r <= CW'(DEPTH - NOUT));
  assign count_nxt = count_r + CW'(wr_cnt) - CW'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < NOUT; i++) begin
      if (i < int'(wr_cnt)) mem_r[wr_ptr_r + AW'(i)] <= wr_res[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + AW'(wr_cnt);
      rd_ptr_r <= rd_ptr_r + AW'(pop);
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_cnt != 2'd0 |-> room)
    else $error("write into queue without room");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    pop && wr_cnt == 2'd0 |=> count_r == $past(count_r) - CW'(1))
    else $error("queue count wrong after read");
`endif

endmodule
